[design/mmie_pkg.sv]
// ----------------------------------------------------------------------------
// mmie_pkg
// Shared types and encodings for the mini MIPS instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

package mmie_pkg;

    localparam int PC_W   = 27;
    localparam int WORD_W = 32;
    localparam int RIDX_W = 5;
    localparam int MIDX_W = 7;
    localparam int BASE_W = 16;

    localparam logic [PC_W-1:0]   PC_RESET   = 27'd128;
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd256;
    localparam logic [PC_W-1:0]   PC_STEP    = 27'd4;

    // item kinds
    localparam logic OP_EXEC    = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    // categories, bits 31..30
    localparam logic [1:0] CAT_CTRL = 2'd0;
    localparam logic [1:0] CAT_ALU  = 2'd1;
    localparam logic [1:0] CAT_IMM  = 2'd2;

    // control and memory opcodes, bits 29..26
    localparam logic [3:0] OPC_J     = 4'd0;
    localparam logic [3:0] OPC_BEQ   = 4'd2;
    localparam logic [3:0] OPC_BGTZ  = 4'd4;
    localparam logic [3:0] OPC_BREAK = 4'd5;
    localparam logic [3:0] OPC_SW    = 4'd6;
    localparam logic [3:0] OPC_LW    = 4'd7;

    // register ALU opcodes, bits 19..16
    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_MUL = 4'd2;
    localparam logic [3:0] ALU_AND = 4'd3;
    localparam logic [3:0] ALU_OR  = 4'd4;
    localparam logic [3:0] ALU_XOR = 4'd5;
    localparam logic [3:0] ALU_NOR = 4'd6;

    // immediate ALU opcodes, bits 19..16
    localparam logic [3:0] IMM_ADDI = 4'd0;
    localparam logic [3:0] IMM_ANDI = 4'd1;
    localparam logic [3:0] IMM_ORI  = 4'd2;
    localparam logic [3:0] IMM_XORI = 4'd3;

    // outcome of one item
    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              halted;
        logic              reg_write;
        logic [RIDX_W-1:0] reg_index;
        logic [WORD_W-1:0] reg_value;
        logic              mem_write;
        logic [MIDX_W-1:0] mem_index;
        logic [WORD_W-1:0] mem_value;
        logic              bad_address;
        logic              load;        // in-range LW, value comes from the store
    } exec_res_t;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

[design/mmie_regfile.sv]
// ----------------------------------------------------------------------------
// mmie_regfile
// 32 x 32 register file, one write port, two registered read ports with
// write-through bypass. Per-entry valid bits give the all-zero reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mmie_regfile (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [mmie_pkg::RIDX_W-1:0]   rd_addr_a,
    input  wire logic [mmie_pkg::RIDX_W-1:0]   rd_addr_b,
    input  wire mmie_pkg::rf_wr_t              wr,
    output logic      [mmie_pkg::WORD_W-1:0]   rd_data_a,
    output logic      [mmie_pkg::WORD_W-1:0]   rd_data_b
);

    localparam int DEPTH = 2 ** mmie_pkg::RIDX_W;

    logic [mmie_pkg::WORD_W-1:0] rf_mem_reg [DEPTH];
    logic [DEPTH-1:0]            vld_reg;
    logic [mmie_pkg::WORD_W-1:0] rd_a_reg;
    logic [mmie_pkg::WORD_W-1:0] rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            rf_mem_reg[wr.addr] <= wr.data;
        end
    end

    // a write landing on the same edge wins over the stored word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr_a))
                rd_a_reg <= wr.data;
            else if (vld_reg[rd_addr_a])
                rd_a_reg <= rf_mem_reg[rd_addr_a];
            else
                rd_a_reg <= '0;

            if (wr.en && (wr.addr == rd_addr_b))
                rd_b_reg <= wr.data;
            else if (vld_reg[rd_addr_b])
                rd_b_reg <= rf_mem_reg[rd_addr_b];
            else
                rd_b_reg <= '0;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

[design/mmie_dstore.sv]
// ----------------------------------------------------------------------------
// mmie_dstore
// Data word store: one write port, one registered read port, and a
// clearing sweep after reset that zeroes one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmie_dstore #(
    parameter int DATA_WORDS = 128
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(DATA_WORDS)-1:0]      wr_addr,
    input  wire logic [mmie_pkg::WORD_W-1:0]        wr_data,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(DATA_WORDS)-1:0]      rd_addr,
    output logic      [mmie_pkg::WORD_W-1:0]        rd_data,
    output logic                                    busy
);

    localparam int IDX_W = $clog2(DATA_WORDS);

    logic [mmie_pkg::WORD_W-1:0] store_mem_reg [DATA_WORDS];
    logic [mmie_pkg::WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]            clr_cnt_reg;
    logic                        clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(DATA_WORDS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            store_mem_reg[clr_cnt_reg] <= '0;
        else if (wr_en)
            store_mem_reg[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= store_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

[design/mmie_exec.sv]
// ----------------------------------------------------------------------------
// mmie_exec
// Execute logic: decodes one item, forms the next PC, ALU result, branch
// decision and store address check.
// ----------------------------------------------------------------------------
`default_nettype none

module mmie_exec #(
    parameter int DATA_WORDS = 128
) (
    input  wire logic                              op,
    input  wire logic [mmie_pkg::WORD_W-1:0]       instr_word,
    input  wire logic [mmie_pkg::MIDX_W-1:0]       load_index,
    input  wire logic [mmie_pkg::WORD_W-1:0]       load_value,
    input  wire logic [mmie_pkg::WORD_W-1:0]       rs_val,
    input  wire logic [mmie_pkg::WORD_W-1:0]       rt_val,
    input  wire logic [mmie_pkg::PC_W-1:0]         pc,
    input  wire logic                              stopped,
    input  wire logic [mmie_pkg::BASE_W-1:0]       data_base,
    output mmie_pkg::exec_res_t                    res,
    output logic                                   st_we,
    output logic      [$clog2(DATA_WORDS)-1:0]     st_addr
);

    localparam int IDX_W = $clog2(DATA_WORDS);

    logic [1:0]                  cat;
    logic [3:0]                  opc_ctrl;
    logic [3:0]                  opc_alu;
    logic [mmie_pkg::WORD_W-1:0] imm_s;
    logic [mmie_pkg::WORD_W-1:0] imm_z;
    logic [mmie_pkg::WORD_W-1:0] ea;
    logic [mmie_pkg::WORD_W-1:0] ea_off;
    logic [29:0]                 widx;
    logic                        widx_ok;
    logic [mmie_pkg::WORD_W-1:0] li_ext;
    logic                        li_ok;
    logic [mmie_pkg::PC_W-1:0]   pc_p4;
    logic [mmie_pkg::PC_W-1:0]   br_tgt;
    logic [mmie_pkg::WORD_W-1:0] prod;

    assign cat      = instr_word[31:30];
    assign opc_ctrl = instr_word[29:26];
    assign opc_alu  = instr_word[19:16];
    assign imm_s    = {{16{instr_word[15]}}, instr_word[15:0]};
    assign imm_z    = {16'd0, instr_word[15:0]};
    assign ea       = rs_val + imm_s;
    assign ea_off   = ea - {16'd0, data_base};
    assign widx     = ea_off[31:2];
    assign widx_ok  = widx < 30'(DATA_WORDS);
    assign li_ext   = {25'd0, load_index};
    assign li_ok    = li_ext < 32'(DATA_WORDS);
    assign pc_p4    = pc + mmie_pkg::PC_STEP;
    assign br_tgt   = pc_p4 + {imm_s[24:0], 2'b00};
    assign prod     = rs_val * rt_val;

    always_comb
    begin
        res         = '0;
        res.next_pc = pc;
        res.halted  = stopped;
        st_we       = 1'b0;
        st_addr     = widx[IDX_W-1:0];

        if (op == mmie_pkg::OP_PRELOAD)
        begin
            st_addr = li_ext[IDX_W-1:0];
            if (li_ok)
            begin
                st_we         = 1'b1;
                res.mem_write = 1'b1;
                res.mem_index = load_index;
                res.mem_value = load_value;
            end
            else
            begin
                res.bad_address = 1'b1;
            end
        end
        else if (!stopped)
        begin
            res.next_pc = pc_p4;
            case (cat)
                mmie_pkg::CAT_CTRL:
                begin
                    case (opc_ctrl)
                        mmie_pkg::OPC_J:
                            res.next_pc = {instr_word[24:0], 2'b00};
                        mmie_pkg::OPC_BEQ:
                            if (rs_val == rt_val)
                                res.next_pc = br_tgt;
                        mmie_pkg::OPC_BGTZ:
                            if ((rs_val != '0) && !rs_val[31])
                                res.next_pc = br_tgt;
                        mmie_pkg::OPC_BREAK:
                            res.halted = 1'b1;
                        mmie_pkg::OPC_SW:
                            if (widx_ok)
                            begin
                                st_we         = 1'b1;
                                res.mem_write = 1'b1;
                                res.mem_index = widx[mmie_pkg::MIDX_W-1:0];
                                res.mem_value = rt_val;
                            end
                            else
                            begin
                                res.bad_address = 1'b1;
                            end
                        mmie_pkg::OPC_LW:
                            if (widx_ok)
                            begin
                                res.reg_write = 1'b1;
                                res.reg_index = instr_word[20:16];
                                res.load      = 1'b1;
                            end
                            else
                            begin
                                res.bad_address = 1'b1;
                            end
                        default:
                            ;
                    endcase
                end
                mmie_pkg::CAT_ALU:
                begin
                    res.reg_write = 1'b1;
                    res.reg_index = instr_word[15:11];
                    case (opc_alu)
                        mmie_pkg::ALU_ADD: res.reg_value = rs_val + rt_val;
                        mmie_pkg::ALU_SUB: res.reg_value = rs_val - rt_val;
                        mmie_pkg::ALU_MUL: res.reg_value = prod;
                        mmie_pkg::ALU_AND: res.reg_value = rs_val & rt_val;
                        mmie_pkg::ALU_OR:  res.reg_value = rs_val | rt_val;
                        mmie_pkg::ALU_XOR: res.reg_value = rs_val ^ rt_val;
                        mmie_pkg::ALU_NOR: res.reg_value = ~(rs_val | rt_val);
                        default:
                        begin
                            res.reg_write = 1'b0;
                            res.reg_index = '0;
                        end
                    endcase
                end
                mmie_pkg::CAT_IMM:
                begin
                    res.reg_write = 1'b1;
                    res.reg_index = instr_word[24:20];
                    case (opc_alu)
                        mmie_pkg::IMM_ADDI: res.reg_value = rs_val + imm_s;
                        mmie_pkg::IMM_ANDI: res.reg_value = rs_val & imm_z;
                        mmie_pkg::IMM_ORI:  res.reg_value = rs_val | imm_z;
                        mmie_pkg::IMM_XORI: res.reg_value = rs_val ^ imm_z;
                        default:
                        begin
                            res.reg_write = 1'b0;
                            res.reg_index = '0;
                        end
                    endcase
                end
                default:
                    ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/mini_mips_instruction_executor_top.sv]
// ----------------------------------------------------------------------------
// mini_mips_instruction_executor_top
// Executes a small MIPS-like instruction subset, one instruction or data
// store preload per input transfer, one result transfer per input.
// ----------------------------------------------------------------------------
// Rate: one item per clock in steady state, while no load hazard or result
// stall holds the input. A result is offered once its item has left the
// execute stage for the result register. The register file is read
// at the input transfer edge into registered read ports, the execute logic
// works in the stage after that, and the result register is the second
// stage. An LW that hits the store takes its value from the store's
// registered read port, read as the load moves into the result stage, so
// the input stalls while such a load sits in the execute stage.
// After reset the data store is swept to zero, one word per cycle, through
// all DATA_WORDS words; input is stalled during the sweep, while configuration
// writes are taken at any time. A stalled result holds the result register,
// and one further item may wait in the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_mips_instruction_executor_top #(
    parameter int DATA_WORDS = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                op,
    input  wire logic [31:0]         instr_word,
    input  wire logic [6:0]          load_index,
    input  wire logic signed [31:0]  load_value,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [26:0]              next_pc,
    output logic                     halted,
    output logic                     reg_write,
    output logic [4:0]               reg_index,
    output logic signed [31:0]       reg_value,
    output logic                     mem_write,
    output logic [6:0]               mem_index,
    output logic signed [31:0]       mem_value,
    output logic                     bad_address
);

    localparam int IDX_W = $clog2(DATA_WORDS);

    // architectural state
    logic [mmie_pkg::PC_W-1:0]   pc_reg;
    logic                        stopped_reg;
    logic [mmie_pkg::BASE_W-1:0] base_reg;

    // execute stage
    logic                        s1_valid_reg;
    logic                        s1_op_reg;
    logic [31:0]                 s1_iw_reg;
    logic [6:0]                  s1_li_reg;
    logic [31:0]                 s1_lv_reg;

    // result stage
    logic                        s2_valid_reg;
    mmie_pkg::exec_res_t         s2_res_reg;
    logic                        s2_load_reg;   // reg_value comes from the store read port
    logic                        s2_pend_reg;   // load value still to go into the register file

    logic                        accept;
    logic                        s2_ready;
    logic                        s1_ready;
    logic                        s1_adv;
    logic                        load_hazard;
    logic                        clr_busy;

    logic [4:0]                  rd_addr_a;
    logic [4:0]                  rd_addr_b;
    logic [31:0]                 rs_val;
    logic [31:0]                 rt_val;
    mmie_pkg::rf_wr_t            rf_wr;

    mmie_pkg::exec_res_t         ex_res;
    logic                        st_we;
    logic [IDX_W-1:0]            st_addr;
    logic [31:0]                 ld_data;

    // ------------------------------------------------------------------
    // Handshake: the result register frees when its transfer completes,
    // the execute stage moves on when the result register can take it.
    // ------------------------------------------------------------------
    assign s2_ready    = !s2_valid_reg || !out_stall;
    assign s1_adv      = s1_valid_reg && s2_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    // an in-range LW in execute must reach the result stage before anyone
    // reads the register file again
    assign load_hazard = s1_valid_reg && ex_res.load;
    assign in_stall    = clr_busy || !s1_ready || load_hazard;
    assign accept      = in_valid && !in_stall;

    // register operand fields sit at different bits per category
    assign rd_addr_a = (instr_word[31:30] == mmie_pkg::CAT_CTRL) ? instr_word[25:21]
                                                                 : instr_word[29:25];
    assign rd_addr_b = (instr_word[31:30] == mmie_pkg::CAT_CTRL) ? instr_word[20:16]
                                                                 : instr_word[24:20];

    // ALU results commit as the item leaves execute; a load commits from the
    // result stage through its pending flag, when execute is always empty
    always_comb
    begin
        if (s2_pend_reg)
        begin
            rf_wr.en   = 1'b1;
            rf_wr.addr = s2_res_reg.reg_index;
            rf_wr.data = ld_data;
        end
        else
        begin
            rf_wr.en   = s1_adv && ex_res.reg_write && !ex_res.load;
            rf_wr.addr = ex_res.reg_index;
            rf_wr.data = ex_res.reg_value;
        end
    end

    mmie_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr        (rf_wr),
        .rd_data_a (rs_val),
        .rd_data_b (rt_val)
    );

    mmie_exec #(
        .DATA_WORDS (DATA_WORDS)
    ) u_exec (
        .op         (s1_op_reg),
        .instr_word (s1_iw_reg),
        .load_index (s1_li_reg),
        .load_value (s1_lv_reg),
        .rs_val     (rs_val),
        .rt_val     (rt_val),
        .pc         (pc_reg),
        .stopped    (stopped_reg),
        .data_base  (base_reg),
        .res        (ex_res),
        .st_we      (st_we),
        .st_addr    (st_addr)
    );

    mmie_dstore #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dstore (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_adv && st_we),
        .wr_addr (st_addr),
        .wr_data (ex_res.mem_value),
        .rd_en   (s1_adv),
        .rd_addr (st_addr),
        .rd_data (ld_data),
        .busy    (clr_busy)
    );

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= mmie_pkg::PC_RESET;
            stopped_reg  <= 1'b0;
            base_reg     <= mmie_pkg::BASE_RESET;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_load_reg  <= 1'b0;
            s2_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                base_reg <= cfg_wr_data;

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                pc_reg       <= ex_res.next_pc;
                stopped_reg  <= ex_res.halted;
                s2_valid_reg <= 1'b1;
                s2_load_reg  <= ex_res.load;
            end
            else if (s2_ready)
            begin
                s2_valid_reg <= 1'b0;
            end

            s2_pend_reg <= s1_adv && ex_res.load;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= op;
            s1_iw_reg <= instr_word;
            s1_li_reg <= load_index;
            s1_lv_reg <= $unsigned(load_value);
        end
        if (s1_adv)
            s2_res_reg <= ex_res;
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign out_valid   = s2_valid_reg;
    assign next_pc     = s2_res_reg.next_pc;
    assign halted      = s2_res_reg.halted;
    assign reg_write   = s2_res_reg.reg_write;
    assign reg_index   = s2_res_reg.reg_index;
    assign reg_value   = $signed(s2_load_reg ? ld_data : s2_res_reg.reg_value);
    assign mem_write   = s2_res_reg.mem_write;
    assign mem_index   = s2_res_reg.mem_index;
    assign mem_value   = $signed(s2_res_reg.mem_value);
    assign bad_address = s2_res_reg.bad_address;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the deferred load write has the register file port to itself
    a_pend_alone: assert property (@(posedge clk) disable iff (!rst_n)
        s2_pend_reg |-> !s1_valid_reg)
        else $error("load write-back overlaps an item in execute");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("halt flag dropped");

    // nothing moves the PC once halted
    a_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg && s1_adv) |-> (ex_res.next_pc == pc_reg))
        else $error("PC changed after halt");

    // no item enters while the store is being swept
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s1_valid_reg && !s2_valid_reg)
        else $error("item in flight during store clear");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mini MIPS instruction executor. Mixes
// instructions and data store preloads, predicts each result transfer from a
// shadow copy of registers, store, PC and halt state, and checks every field
// in order. Input and output sides stall at random. The data base register
// changes between phases. A BREAK near the end halts the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD  = 10;
    localparam int DATA_WORDS  = 128;
    localparam int RESET_TICKS = 6;
    localparam int LONG_HOLD   = 300;     // receiver hold-off, in cycles
    localparam int TAIL_WAIT   = 8;       // pause after the final drain, with margin
    localparam int CYCLE_LIMIT = 300000;

    // encodings the block must treat as no-ops
    localparam logic [1:0] CAT_NONE   = 2'd3;
    localparam logic [3:0] ALU_UNUSED = 4'd7;
    localparam logic [3:0] IMM_UNUSED = 4'd15;
    localparam logic [3:0] OPC_UNUSED = 4'd15;

    // one result transfer, field for field as on the ports
    typedef struct packed {
        logic [mmie_pkg::PC_W-1:0]   next_pc;
        logic                        halted;
        logic                        reg_write;
        logic [mmie_pkg::RIDX_W-1:0] reg_index;
        logic [mmie_pkg::WORD_W-1:0] reg_value;
        logic                        mem_write;
        logic [mmie_pkg::MIDX_W-1:0] mem_index;
        logic [mmie_pkg::WORD_W-1:0] mem_value;
        logic                        bad_address;
    } step_out_t;

    // ------------------------------------------------------------------------
    // Shadow core: architectural state plus the queue of predicted results.
    // ------------------------------------------------------------------------
    class step_predictor;
        logic [mmie_pkg::WORD_W-1:0] regs [32];
        logic [mmie_pkg::WORD_W-1:0] dstore [DATA_WORDS];
        logic [mmie_pkg::PC_W-1:0]   pc;
        logic [mmie_pkg::BASE_W-1:0] base_addr;
        bit                          halt_seen;
        step_out_t                   expected_steps [$];
        int                          fail_count;
        int                          checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dstore[i]) dstore[i] = '0;
            pc         = mmie_pkg::PC_RESET;
            base_addr  = mmie_pkg::BASE_RESET;
            halt_seen  = 1'b0;
            fail_count = 0;
            checked    = 0;
        endfunction

        function int outstanding();
            return expected_steps.size();
        endfunction

        // Word index of a byte address relative to the data base; wraps, so
        // addresses below the base land far outside the store.
        function logic [31:0] word_of(logic [31:0] addr);
            return (addr - {16'b0, base_addr}) >> 2;
        endfunction

        // Apply one accepted input transfer and queue what it should produce.
        function void note_transfer_in(logic kind, logic [31:0] iw,
                                       logic [6:0] li, logic [31:0] lv);
            step_out_t   r;
            logic [3:0]  opc;
            logic [4:0]  rs, rt, ri;
            logic [31:0] sx, zx, a, b, res, widx;
            bit          ok;
            r = '0;
            r.next_pc = pc;
            sx = {{16{iw[15]}}, iw[15:0]};
            zx = {16'b0, iw[15:0]};
            if (kind == mmie_pkg::OP_PRELOAD)
            begin
                // preload goes through even after a halt
                if (li < DATA_WORDS)
                begin
                    dstore[li]  = lv;
                    r.mem_write = 1'b1;
                    r.mem_index = li;
                    r.mem_value = lv;
                end
                else
                begin
                    r.bad_address = 1'b1;
                end
            end
            else if (!halt_seen)
            begin
                r.next_pc = pc + mmie_pkg::PC_STEP;
                if (iw[31:30] == mmie_pkg::CAT_CTRL)
                begin
                    opc  = iw[29:26];
                    rs   = iw[25:21];
                    rt   = iw[20:16];
                    widx = word_of(regs[rs] + sx);
                    case (opc)
                        mmie_pkg::OPC_J:
                            r.next_pc = {iw[24:0], 2'b00};
                        mmie_pkg::OPC_BEQ:
                            if (regs[rs] == regs[rt])
                                r.next_pc = pc + mmie_pkg::PC_STEP + {sx[24:0], 2'b00};
                        mmie_pkg::OPC_BGTZ:
                            if (regs[rs] != '0 && !regs[rs][31])
                                r.next_pc = pc + mmie_pkg::PC_STEP + {sx[24:0], 2'b00};
                        mmie_pkg::OPC_BREAK:
                            halt_seen = 1'b1;
                        mmie_pkg::OPC_SW:
                            if (widx < DATA_WORDS)
                            begin
                                dstore[widx] = regs[rt];
                                r.mem_write  = 1'b1;
                                r.mem_index  = widx[mmie_pkg::MIDX_W-1:0];
                                r.mem_value  = regs[rt];
                            end
                            else
                            begin
                                r.bad_address = 1'b1;
                            end
                        mmie_pkg::OPC_LW:
                            if (widx < DATA_WORDS)
                            begin
                                regs[rt]    = dstore[widx];
                                r.reg_write = 1'b1;
                                r.reg_index = rt;
                                r.reg_value = dstore[widx];
                            end
                            else
                            begin
                                r.bad_address = 1'b1;
                            end
                        default: ;
                    endcase
                end
                else if (iw[31:30] == mmie_pkg::CAT_ALU || iw[31:30] == mmie_pkg::CAT_IMM)
                begin
                    rs  = iw[29:25];
                    rt  = iw[24:20];
                    opc = iw[19:16];
                    a   = regs[rs];
                    b   = regs[rt];
                    ok  = 1'b1;
                    res = '0;
                    if (iw[31:30] == mmie_pkg::CAT_ALU)
                    begin
                        ri = iw[15:11];
                        case (opc)
                            mmie_pkg::ALU_ADD: res = a + b;
                            mmie_pkg::ALU_SUB: res = a - b;
                            mmie_pkg::ALU_MUL: res = a * b;
                            mmie_pkg::ALU_AND: res = a & b;
                            mmie_pkg::ALU_OR:  res = a | b;
                            mmie_pkg::ALU_XOR: res = a ^ b;
                            mmie_pkg::ALU_NOR: res = ~(a | b);
                            default:           ok = 1'b0;
                        endcase
                    end
                    else
                    begin
                        ri = rt;
                        case (opc)
                            mmie_pkg::IMM_ADDI: res = a + sx;
                            mmie_pkg::IMM_ANDI: res = a & zx;
                            mmie_pkg::IMM_ORI:  res = a | zx;
                            mmie_pkg::IMM_XORI: res = a ^ zx;
                            default:            ok = 1'b0;
                        endcase
                    end
                    if (ok)
                    begin
                        regs[ri]    = res;
                        r.reg_write = 1'b1;
                        r.reg_index = ri;
                        r.reg_value = res;
                    end
                end
                // category 11: PC step only
            end
            pc       = r.next_pc;
            r.halted = halt_seen;
            expected_steps.insert(expected_steps.size(), r);
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            $display("[%0t] mismatch at result %0d: %s", $realtime, checked, msg);
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %h, expected %h", field, got, want));
        endtask

        task check_transfer_out(step_out_t got);
            step_out_t want;
            if (expected_steps.size() == 0)
            begin
                report_mismatch("result transfer with nothing expected");
                return;
            end
            want = expected_steps.pop_front();
            checked++;
            compare_field("next_pc",     32'(got.next_pc),     32'(want.next_pc));
            compare_field("halted",      32'(got.halted),      32'(want.halted));
            compare_field("reg_write",   32'(got.reg_write),   32'(want.reg_write));
            compare_field("reg_index",   32'(got.reg_index),   32'(want.reg_index));
            compare_field("reg_value",   got.reg_value,        want.reg_value);
            compare_field("mem_write",   32'(got.mem_write),   32'(want.mem_write));
            compare_field("mem_index",   32'(got.mem_index),   32'(want.mem_index));
            compare_field("mem_value",   got.mem_value,        want.mem_value);
            compare_field("bad_address", 32'(got.bad_address), 32'(want.bad_address));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [15:0]        cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               op          = mmie_pkg::OP_EXEC;
    logic [31:0]        instr_word  = '0;
    logic [6:0]         load_index  = '0;
    logic signed [31:0] load_value  = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [26:0]        next_pc;
    logic               halted;
    logic               reg_write;
    logic [4:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_write;
    logic [6:0]         mem_index;
    logic signed [31:0] mem_value;
    logic               bad_address;

    // idle rates per side, percent of cycles; changed by the main sequence
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // long hold-off requests: main bumps hold_asks, receiver bumps hold_done
    int hold_asks = 0;
    int hold_done = 0;
    int cycle_count = 0;

    step_predictor shadow_core = new();

    mini_mips_instruction_executor_top #(
        .DATA_WORDS (DATA_WORDS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .instr_word  (instr_word),
        .load_index  (load_index),
        .load_value  (load_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_pc     (next_pc),
        .halted      (halted),
        .reg_write   (reg_write),
        .reg_index   (reg_index),
        .reg_value   (reg_value),
        .mem_write   (mem_write),
        .mem_index   (mem_index),
        .mem_value   (mem_value),
        .bad_address (bad_address)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run limit. Covers the post-reset sweep, the long hold-off and every
    // transfer waiting out worst-case idling on both sides, with wide margin.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver side. Stall is redrawn every cycle; a pending hold-off request
    // pins it high for the LONG_HOLD stretch so the pipe fills and backs up into
    // in_stall while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin : result_stall_driver
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_done++;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Result monitor. Values read right after the edge are the ones the block
    // saw at that edge, since every input changes in the NBA region.
    always @(posedge clk)
    begin : result_monitor
        step_out_t seen;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen.next_pc     = next_pc;
            seen.halted      = halted;
            seen.reg_write   = reg_write;
            seen.reg_index   = reg_index;
            seen.reg_value   = reg_value;
            seen.mem_write   = mem_write;
            seen.mem_index   = mem_index;
            seen.mem_value   = mem_value;
            seen.bad_address = bad_address;
            shadow_core.check_transfer_out(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one item and wait for its transfer. Valid is left high on return
    // so back-to-back items keep it up without a drop; callers that stop
    // sending lower it explicitly.
    task automatic send_item(logic kind, logic [31:0] iw, logic [6:0] li, logic [31:0] lv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        instr_word <= iw;
        load_index <= li;
        load_value <= lv;
        do @(posedge clk); while (in_stall !== 1'b0);
        shadow_core.note_transfer_in(kind, iw, li, lv);
    endtask

    // unused payload fields still toggle
    task automatic send_exec(logic [31:0] iw);
        send_item(mmie_pkg::OP_EXEC, iw, 7'($urandom), $urandom);
    endtask

    task automatic send_preload(logic [6:0] li, logic [31:0] lv);
        send_item(mmie_pkg::OP_PRELOAD, $urandom, li, lv);
    endtask

    // Stop offering and wait until every predicted result has been seen.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (shadow_core.outstanding() != 0);
    endtask

    // Only called with the block idle.
    task automatic write_data_base(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_core.base_addr = v;
    endtask

    function automatic logic [31:0] enc_alu(logic [3:0] opc, logic [4:0] rs, logic [4:0] rt,
                                            logic [4:0] rd);
        return {mmie_pkg::CAT_ALU, rs, rt, opc, rd, 11'($urandom)};
    endfunction

    function automatic logic [31:0] enc_imm(logic [3:0] opc, logic [4:0] rs, logic [4:0] rt,
                                            logic [15:0] imm);
        return {mmie_pkg::CAT_IMM, rs, rt, opc, imm};
    endfunction

    function automatic logic [31:0] enc_ctrl(logic [3:0] opc, logic [4:0] rs, logic [4:0] rt,
                                             logic [15:0] imm);
        return {mmie_pkg::CAT_CTRL, opc, rs, rt, imm};
    endfunction

    // Bias toward a few registers so results feed straight into later
    // instructions, including right behind a load.
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(9) < 7) ? 5'($urandom_range(7)) : 5'($urandom);
    endfunction

    // SW or LW. When aimed, the offset is computed from the shadow register
    // so the byte address lands on word widx (low bits lowb); if the base
    // register is too far away it is first reloaded with the data base.
    task automatic mem_access(logic [3:0] opc, logic [4:0] rs, logic [4:0] rt, bit aim,
                              int widx, int lowb);
        logic [31:0] target, diff;
        logic [15:0] offs;
        if (aim)
        begin
            target = {16'b0, shadow_core.base_addr} + 32'(widx * 4 + lowb);
            diff   = target - shadow_core.regs[rs];
            if ($signed(diff) < -32768 || $signed(diff) > 32767)
            begin
                send_exec(enc_imm(mmie_pkg::IMM_ANDI, rs, rs, 16'h0000));
                send_exec(enc_imm(mmie_pkg::IMM_ORI, rs, rs, shadow_core.base_addr));
                diff = target - shadow_core.regs[rs];
            end
            offs = diff[15:0];
        end
        else
        begin
            offs = 16'($urandom);
        end
        send_exec(enc_ctrl(opc, rs, rt, offs));
    endtask

    // One random item; never a BREAK, which is saved for the very end.
    task automatic random_item();
        int          pick;
        logic [3:0]  opc;
        logic [4:0]  rs, rt;
        logic [15:0] imm;
        pick = $urandom_range(99);
        rs   = pick_reg();
        rt   = pick_reg();
        imm  = ($urandom_range(3) == 0) ? 16'($signed(5'($urandom))) : 16'($urandom);
        if (pick < 10)
        begin
            send_preload(7'($urandom), $urandom);
        end
        else if (pick < 26)
        begin
            mem_access(($urandom_range(1) != 0) ? mmie_pkg::OPC_SW : mmie_pkg::OPC_LW,
                       rs, rt, $urandom_range(9) < 8, $urandom_range(DATA_WORDS + 3),
                       $urandom_range(3));
        end
        else if (pick < 64)
        begin
            opc = ($urandom_range(19) == 0) ? 4'($urandom_range(15, ALU_UNUSED))
                                             : 4'($urandom_range(mmie_pkg::ALU_NOR));
            send_exec(enc_alu(opc, rs, rt, pick_reg()));
        end
        else if (pick < 86)
        begin
            opc = ($urandom_range(19) == 0) ? 4'($urandom_range(15, mmie_pkg::IMM_XORI + 1))
                                             : 4'($urandom_range(mmie_pkg::IMM_XORI));
            send_exec(enc_imm(opc, rs, rt, imm));
        end
        else if (pick < 96)
        begin
            case ($urandom_range(2))
                0:       send_exec(enc_ctrl(mmie_pkg::OPC_BEQ, rs,
                                            ($urandom_range(2) == 0) ? rs : rt, imm));
                1:       send_exec(enc_ctrl(mmie_pkg::OPC_BGTZ, rs, rt, imm));
                default: send_exec({mmie_pkg::CAT_CTRL, mmie_pkg::OPC_J, 26'($urandom)});
            endcase
        end
        else if ($urandom_range(1) != 0)
        begin
            send_exec({CAT_NONE, 30'($urandom)});
        end
        else
        begin
            // control category with an opcode that has no meaning
            do opc = 4'($urandom);
            while (opc == mmie_pkg::OPC_J || opc == mmie_pkg::OPC_BEQ ||
                   opc == mmie_pkg::OPC_BGTZ || opc == mmie_pkg::OPC_BREAK ||
                   opc == mmie_pkg::OPC_SW || opc == mmie_pkg::OPC_LW);
            send_exec(enc_ctrl(opc, rs, rt, imm));
        end
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            random_item();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;

        // Config writes are taken during the post-reset sweep; the first
        // input transfers simply wait on in_stall until it is done.
        write_data_base(16'h0000);

        // Phase 1: sender idles a third of the time, receiver mostly stalls.
        send_idle_pct = 36;
        recv_idle_pct = 79;

        // Directed: field extremes, every ALU form, no-op encodings, branch
        // and jump edge cases, store hits at both ends and misses.
        send_preload(7'd0,   32'h8000_0000);
        send_preload(7'd127, 32'h7FFF_FFFF);
        send_preload(7'd42,  32'hFFFF_FFFF);
        send_exec(enc_imm(mmie_pkg::IMM_ORI,  5'd0, 5'd1, 16'hFFFF));   // zero-extended
        send_exec(enc_imm(mmie_pkg::IMM_ADDI, 5'd0, 5'd2, 16'h8000));   // sign-extended
        send_exec(enc_imm(mmie_pkg::IMM_ADDI, 5'd0, 5'd3, 16'h7FFF));
        send_exec(enc_imm(mmie_pkg::IMM_XORI, 5'd2, 5'd4, 16'hFFFF));
        send_exec(enc_imm(mmie_pkg::IMM_ANDI, 5'd2, 5'd5, 16'hFFFF));
        send_exec(enc_alu(mmie_pkg::ALU_ADD, 5'd2, 5'd2, 5'd6));
        send_exec(enc_alu(mmie_pkg::ALU_SUB, 5'd0, 5'd3, 5'd8));
        send_exec(enc_alu(mmie_pkg::ALU_MUL, 5'd2, 5'd2, 5'd7));
        send_exec(enc_alu(mmie_pkg::ALU_AND, 5'd1, 5'd2, 5'd9));
        send_exec(enc_alu(mmie_pkg::ALU_OR,  5'd1, 5'd2, 5'd10));
        send_exec(enc_alu(mmie_pkg::ALU_XOR, 5'd4, 5'd5, 5'd11));
        send_exec(enc_alu(mmie_pkg::ALU_NOR, 5'd1, 5'd3, 5'd0));       // r0 is writable
        send_exec(enc_alu(ALU_UNUSED, 5'd1, 5'd2, 5'd13));
        send_exec(enc_imm(IMM_UNUSED, 5'd1, 5'd14, 16'h1234));
        send_exec(32'hFFFF_FFFF);                                       // category 11
        send_exec(enc_ctrl(OPC_UNUSED, 5'd1, 5'd2, 16'hFFFF));
        send_exec(enc_ctrl(mmie_pkg::OPC_BEQ, 5'd3, 5'd3, 16'h8000));   // taken back, wraps
        send_exec(enc_ctrl(mmie_pkg::OPC_BGTZ, 5'd3, 5'd0, 16'h7FFF));  // positive: taken
        send_exec(enc_ctrl(mmie_pkg::OPC_BGTZ, 5'd2, 5'd0, 16'h0010));  // negative: not taken
        send_exec(enc_ctrl(mmie_pkg::OPC_BGTZ, 5'd12, 5'd0, 16'h0010)); // zero: not taken
        // next step wraps the PC
        send_exec({mmie_pkg::CAT_CTRL, mmie_pkg::OPC_J, 1'b0, 25'h1FF_FFFF});
        mem_access(mmie_pkg::OPC_SW, 5'd6, 5'd1, 1'b1, 0, 0);
        mem_access(mmie_pkg::OPC_LW, 5'd6, 5'd15, 1'b1, DATA_WORDS - 1, 3);
        mem_access(mmie_pkg::OPC_LW, 5'd2, 5'd16, 1'b0, 0, 0);          // negative address: miss
        mem_access(mmie_pkg::OPC_SW, 5'd6, 5'd1, 1'b1, DATA_WORDS, 0);  // one past the end
        drain();

        // Random traffic at the same rates; midway the receiver holds off
        // for a long stretch.
        write_data_base(16'hFFFC);
        run_random(120);
        hold_asks++;
        run_random(240);
        drain();

        // Phase 2: roles swapped; the sender pauses until everything is back.
        write_data_base(mmie_pkg::BASE_RESET);
        send_idle_pct = 79;
        recv_idle_pct = 36;
        run_random(180);
        drain();
        run_random(180);
        drain();

        // Phase 3: full rate both ways, then halt. After BREAK instructions
        // are ignored but preloads still land.
        write_data_base(16'($urandom_range(16383) * 4));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(360);
        send_exec(enc_ctrl(mmie_pkg::OPC_BREAK, pick_reg(), pick_reg(), 16'($urandom)));
        run_random(6);
        send_preload(7'($urandom), $urandom);
        drain();

        repeat (TAIL_WAIT) @(posedge clk);
        if (shadow_core.fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
